>>> rtl/cnftp_pkg.sv
// Shared types and constants for the CNF token parser.
`default_nettype none

package cnftp_pkg;

  localparam int TOKEN_W = 21;
  localparam int KIND_W  = 3;
  localparam int EVENT_W = 3;
  localparam int ERR_W   = 3;
  localparam int WARN_W  = 3;

  typedef enum logic [KIND_W-1:0] {
    TK_COMMENT  = 3'd0,
    TK_HEADER   = 3'd1,
    TK_NUMBER   = 3'd2,
    TK_ZERO     = 3'd3,
    TK_NEWLINE  = 3'd4,
    TK_EOF      = 3'd5,
    TK_SCAN_ERR = 3'd6
  } tkind_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 3'd0,
    EV_HEADER = 3'd1,
    EV_LIT    = 3'd2,
    EV_CLAUSE = 3'd3,
    EV_DONE   = 3'd4,
    EV_ERROR  = 3'd5
  } event_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE       = 3'd0,
    ERR_DUP_HEADER = 3'd1,
    ERR_EARLY_EOF  = 3'd2,
    ERR_HDR_SYNTAX = 3'd3,
    ERR_CLS_SYNTAX = 3'd4,
    ERR_SCANNER    = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    PH_WAIT_HDR   = 3'd0,
    PH_WANT_VARS  = 3'd1,
    PH_WANT_CLS   = 3'd2,
    PH_HDR_NL     = 3'd3,
    PH_LINE_START = 3'd4,
    PH_IN_CLAUSE  = 3'd5,
    PH_AFTER_ZERO = 3'd6
  } phase_t;

endpackage

`default_nettype wire

>>> rtl/cnftp_in_stage.sv
// Input register stage that holds one token item for the parse step.
`default_nettype none

module cnftp_in_stage
  import cnftp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [KIND_W-1:0]         in_kind,
  input  wire logic signed [TOKEN_W-1:0] in_value,
  output logic                           step_en,
  input  wire logic                      down_ready,
  output logic [KIND_W-1:0]              tok_kind,
  output logic signed [TOKEN_W-1:0]      tok_value
);

  logic                      valid_r;
  logic [KIND_W-1:0]         kind_r;
  logic signed [TOKEN_W-1:0] value_r;

  assign step_en   = valid_r && down_ready;
  assign in_ready  = !valid_r || down_ready;
  assign tok_kind  = kind_r;
  assign tok_value = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cnftp_core.sv
// Parse state registers and the per-token decision logic.
`default_nettype none

module cnftp_core
  import cnftp_pkg::*;
#(
  parameter int VAR_BITS    = 20,
  parameter int CLAUSE_BITS = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step_en,
  input  wire logic [KIND_W-1:0]         tok_kind,
  input  wire logic signed [TOKEN_W-1:0] tok_value,
  output logic [EVENT_W-1:0]             res_event,
  output logic signed [TOKEN_W-1:0]      res_literal,
  output logic [VAR_BITS-1:0]            res_vars,
  output logic [CLAUSE_BITS-1:0]         res_clauses,
  output logic [CLAUSE_BITS-1:0]         res_total,
  output logic [VAR_BITS-1:0]            res_largest,
  output logic [ERR_W-1:0]               res_err,
  output logic [WARN_W-1:0]              res_warn
);

  localparam int VMW = (VAR_BITS > TOKEN_W) ? VAR_BITS : TOKEN_W;
  localparam int CMW = (CLAUSE_BITS > TOKEN_W) ? CLAUSE_BITS : TOKEN_W;

  phase_t                 phase_r, phase_nxt;
  logic [VAR_BITS-1:0]    hvars_r, hvars_nxt;
  logic [CLAUSE_BITS-1:0] hcls_r, hcls_nxt;
  logic [VAR_BITS-1:0]    maxv_r, maxv_nxt;
  logic [CLAUSE_BITS-1:0] seen_r, seen_nxt;
  logic                   finished_r, finished_nxt;

  logic [KIND_W-1:0]      kind_eff;
  logic                   neg;
  logic [TOKEN_W-1:0]     mag;
  logic [VMW-1:0]         mag_v;
  logic [VMW-1:0]         vmax_v;
  logic [CMW-1:0]         mag_c;
  logic [CMW-1:0]         cmax_c;
  logic [VAR_BITS-1:0]    mag_var_sat;
  logic [CLAUSE_BITS-1:0] mag_cls_sat;
  event_t                 ev;
  err_t                   err;
  logic [WARN_W-1:0]      warn;

  // A number token of value zero behaves as the clause terminator.
  assign kind_eff = (tok_kind == TK_NUMBER && tok_value == '0) ? TK_ZERO : tok_kind;
  assign neg      = tok_value[TOKEN_W-1];
  assign mag      = neg ? (~tok_value + 1'b1) : tok_value;
  assign mag_v    = VMW'(mag);
  assign vmax_v   = VMW'({VAR_BITS{1'b1}});
  assign mag_c    = CMW'(mag);
  assign cmax_c   = CMW'({CLAUSE_BITS{1'b1}});
  assign mag_var_sat = (mag_v > vmax_v) ? VAR_BITS'(vmax_v) : VAR_BITS'(mag_v);
  assign mag_cls_sat = (mag_c > cmax_c) ? CLAUSE_BITS'(cmax_c) : CLAUSE_BITS'(mag_c);

  always_comb begin
    phase_nxt    = phase_r;
    hvars_nxt    = hvars_r;
    hcls_nxt     = hcls_r;
    maxv_nxt     = maxv_r;
    seen_nxt     = seen_r;
    finished_nxt = finished_r;
    ev           = EV_NONE;
    err          = ERR_NONE;
    warn         = '0;
    if (!finished_r && kind_eff != TK_COMMENT) begin
      if (kind_eff >= TK_SCAN_ERR) begin
        ev  = EV_ERROR;
        err = ERR_SCANNER;
      end else begin
        unique case (phase_r)
          PH_WAIT_HDR: begin
            if (kind_eff == TK_HEADER) begin
              phase_nxt = PH_WANT_VARS;
            end else if (kind_eff == TK_EOF) begin
              ev  = EV_ERROR;
              err = ERR_EARLY_EOF;
            end
          end
          PH_WANT_VARS: begin
            if (kind_eff == TK_NUMBER && !neg) begin
              hvars_nxt = mag_var_sat;
              phase_nxt = PH_WANT_CLS;
            end else begin
              ev  = EV_ERROR;
              err = ERR_HDR_SYNTAX;
            end
          end
          PH_WANT_CLS: begin
            if (kind_eff == TK_NUMBER && !neg) begin
              hcls_nxt  = mag_cls_sat;
              phase_nxt = PH_HDR_NL;
            end else begin
              ev  = EV_ERROR;
              err = ERR_HDR_SYNTAX;
            end
          end
          PH_HDR_NL: begin
            if (kind_eff == TK_NEWLINE) begin
              ev        = EV_HEADER;
              phase_nxt = PH_LINE_START;
            end else begin
              ev  = EV_ERROR;
              err = ERR_HDR_SYNTAX;
            end
          end
          PH_LINE_START, PH_IN_CLAUSE: begin
            if (kind_eff == TK_NUMBER) begin
              if (mag_var_sat > maxv_r) begin
                maxv_nxt = mag_var_sat;
              end
              ev        = EV_LIT;
              phase_nxt = PH_IN_CLAUSE;
            end else if (kind_eff == TK_NEWLINE) begin
              ev = EV_NONE;
            end else if (phase_r == PH_LINE_START && kind_eff == TK_HEADER) begin
              ev  = EV_ERROR;
              err = ERR_DUP_HEADER;
            end else if (phase_r == PH_LINE_START && kind_eff == TK_EOF) begin
              ev = EV_DONE;
            end else if (phase_r == PH_IN_CLAUSE && kind_eff == TK_ZERO) begin
              phase_nxt = PH_AFTER_ZERO;
            end else begin
              ev  = EV_ERROR;
              err = ERR_CLS_SYNTAX;
            end
          end
          PH_AFTER_ZERO: begin
            if (kind_eff == TK_NEWLINE || kind_eff == TK_EOF) begin
              if (seen_r != {CLAUSE_BITS{1'b1}}) begin
                seen_nxt = seen_r + 1'b1;
              end
              phase_nxt = PH_LINE_START;
              ev        = (kind_eff == TK_EOF) ? EV_DONE : EV_CLAUSE;
            end else begin
              ev  = EV_ERROR;
              err = ERR_CLS_SYNTAX;
            end
          end
          default: begin
            ev  = EV_ERROR;
            err = ERR_SCANNER;
          end
        endcase
      end
      if (ev == EV_DONE) begin
        warn[0] = maxv_nxt > hvars_nxt;
        warn[1] = hcls_nxt > seen_nxt;
        warn[2] = hcls_nxt < seen_nxt;
      end
      if (ev == EV_DONE || ev == EV_ERROR) begin
        finished_nxt = 1'b1;
      end
    end
  end

  assign res_event   = ev;
  assign res_literal = (ev == EV_LIT) ? tok_value : '0;
  assign res_vars    = hvars_nxt;
  assign res_clauses = hcls_nxt;
  assign res_total   = seen_nxt;
  assign res_largest = maxv_nxt;
  assign res_err     = err;
  assign res_warn    = warn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT_HDR;
      hvars_r    <= '0;
      hcls_r     <= '0;
      maxv_r     <= '0;
      seen_r     <= '0;
      finished_r <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      hvars_r    <= hvars_nxt;
      hcls_r     <= hcls_nxt;
      maxv_r     <= maxv_nxt;
      seen_r     <= seen_nxt;
      finished_r <= finished_nxt;
    end
  end

  a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag dropped without reset");

  a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res_event == EV_ERROR) |-> (res_err != ERR_NONE))
    else $error("error event without an error code");

  a_warn_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res_event != EV_DONE) |-> (res_warn == '0))
    else $error("warning bits outside a done event");

  a_quiet_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && finished_r) |-> (res_event == EV_NONE && phase_nxt == phase_r))
    else $error("token acted on after the parse finished");

endmodule

`default_nettype wire

>>> rtl/cnftp_out_stage.sv
// Result register that holds one result item until the consumer takes it.
`default_nettype none

module cnftp_out_stage #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  output logic                  can_load,
  input  wire logic [WIDTH-1:0] load_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  logic             valid_r;
  logic [WIDTH-1:0] data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cnf_token_parser_core.sv
// Top level of the CNF token parser: input stage, parse step and result register.
// A token item is registered in the input stage; its result item is then registered in the result register.
// Throughput: one token item per cycle while the result side is ready; the parse step is a single registered pass.
// Backpressure on the result side stalls the input stage one item deep.
// Reset (rst_n low, synchronous) clears the parse phase, header counts,
// largest variable, clause count, finished flag and both stage valid bits.
`default_nettype none

module cnf_token_parser_core
  import cnftp_pkg::*;
#(
  parameter int VAR_BITS    = 20,
  parameter int CLAUSE_BITS = 24,
  localparam int IN_DW      = ((TOKEN_W + 7) / 8) * 8,
  localparam int OUT_BITS   = TOKEN_W + 2 * VAR_BITS + 2 * CLAUSE_BITS + ERR_W + WARN_W,
  localparam int OUT_DW     = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // tdata: token_value
  input  wire logic [IN_DW-1:0]       in_tdata,
  // tuser: token_kind
  input  wire logic [KIND_W-1:0]      in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tdata: literal, declared_vars, declared_clauses, clause_total, largest_var,
  // error_code, warn_flags
  output logic [OUT_DW-1:0]           out_tdata,
  // tuser: event_res
  output logic [EVENT_W-1:0]          out_tuser
);

  localparam int RES_W    = EVENT_W + OUT_DW;

  logic                      step_en;
  logic                      can_load;
  logic [KIND_W-1:0]         tok_kind;
  logic signed [TOKEN_W-1:0] tok_value;
  logic [EVENT_W-1:0]        res_event;
  logic signed [TOKEN_W-1:0] res_literal;
  logic [VAR_BITS-1:0]       res_vars;
  logic [CLAUSE_BITS-1:0]    res_clauses;
  logic [CLAUSE_BITS-1:0]    res_total;
  logic [VAR_BITS-1:0]       res_largest;
  logic [ERR_W-1:0]          res_err;
  logic [WARN_W-1:0]         res_warn;
  logic [OUT_BITS-1:0]       res_fields;
  logic [RES_W-1:0]          res_word;
  logic [RES_W-1:0]          out_word;

  cnftp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_value   (in_tdata[TOKEN_W-1:0]),
    .step_en    (step_en),
    .down_ready (can_load),
    .tok_kind   (tok_kind),
    .tok_value  (tok_value)
  );

  cnftp_core #(
    .VAR_BITS    (VAR_BITS),
    .CLAUSE_BITS (CLAUSE_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .tok_kind    (tok_kind),
    .tok_value   (tok_value),
    .res_event   (res_event),
    .res_literal (res_literal),
    .res_vars    (res_vars),
    .res_clauses (res_clauses),
    .res_total   (res_total),
    .res_largest (res_largest),
    .res_err     (res_err),
    .res_warn    (res_warn)
  );

  assign res_fields = {res_warn, res_err, res_largest, res_total, res_clauses, res_vars,
                       res_literal};
  assign res_word   = {OUT_DW'(res_fields), res_event};

  cnftp_out_stage #(
    .WIDTH (RES_W)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .can_load  (can_load),
    .load_data (res_word),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_word)
  );

  assign out_tuser = out_word[EVENT_W-1:0];
  assign out_tdata = out_word[RES_W-1:EVENT_W];

endmodule

`default_nettype wire
